@@ sv/u2l_pkg.sv @@
// Shared types, constants and the glyph lookup for the UTF-8 to display character mapper.
`timescale 1ns / 1ps
`default_nettype none

package u2l_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 21;
  localparam int unsigned LeftW  = 2;

  // Lead byte masks and their match patterns.
  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Pat  = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Pat  = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Pat  = 8'hF0;

  // Continuation bytes expected after each kind of lead byte.
  localparam logic [LeftW-1:0] Left2 = 2'd1;
  localparam logic [LeftW-1:0] Left3 = 2'd2;
  localparam logic [LeftW-1:0] Left4 = 2'd3;

  localparam logic [ByteW-1:0] CharUnknown = 8'h3F;  // '?'
  localparam logic [ByteW-1:0] CharLowerI  = 8'h69;  // 'i'
  localparam logic [ByteW-1:0] CharUpperI  = 8'h49;  // 'I'

  // Custom glyph slots in the display character generator.
  localparam logic [ByteW-1:0] GlyphAAcute  = 8'd1;
  localparam logic [ByteW-1:0] GlyphEAcute  = 8'd2;
  localparam logic [ByteW-1:0] GlyphOAcute  = 8'd3;
  localparam logic [ByteW-1:0] GlyphOUml    = 8'd4;
  localparam logic [ByteW-1:0] GlyphODblAc  = 8'd5;
  localparam logic [ByteW-1:0] GlyphUAcute  = 8'd6;
  localparam logic [ByteW-1:0] GlyphUUmlDbl = 8'd7;

  // Result of decoding one byte.
  typedef struct packed {
    logic             emit;
    logic [ByteW-1:0] ch;
    logic             last;
  } res_t;

  function automatic logic [ByteW-1:0] map_code(input logic [CodeW-1:0] cp);
    logic [ByteW-1:0] ch;
    case (cp)
      21'h0000C1, 21'h0000E1: ch = GlyphAAcute;
      21'h0000C9, 21'h0000E9: ch = GlyphEAcute;
      21'h0000CD:             ch = CharLowerI;
      21'h0000ED:             ch = CharUpperI;
      21'h0000D3, 21'h0000F3: ch = GlyphOAcute;
      21'h0000D6, 21'h0000F6: ch = GlyphOUml;
      21'h000150, 21'h000151: ch = GlyphODblAc;
      21'h0000DA, 21'h0000FA: ch = GlyphUAcute;
      21'h0000DC, 21'h0000FC,
      21'h000170, 21'h000171: ch = GlyphUUmlDbl;
      default:                ch = CharUnknown;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

@@ sv/utf8_to_lcd_charset_mapper.sv @@
// Top level of the UTF-8 to display character mapper.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+-------------------------
//   in      | sink      | in_valid / in_ready    | in_byte[7:0], in_last
//   out     | source    | out_valid / out_ready  | out_char[7:0], out_last
//
// One byte beat is taken per cycle while in_ready is high. A byte is held in
// the input register, where the decoder updates the sequence state and forms
// the result, and the result is then loaded into the output register, from
// which the character leaves. Lead bytes and inner continuation bytes
// produce no beat on the out side unless they carry the last flag.
// Reset (rst, synchronous, active high) empties both registers and clears
// the sequence state. When the sink stalls, a byte that produces a result
// waits in the input register, and the input side stalls only once that
// register is also full; bytes that produce no result still move on.
//
// Decoding: lead bytes 110xxxxx, 1110xxxx and 11110xxx open sequences of two,
// three and four bytes. The following bytes are taken as continuations and
// contribute their low six bits. A finished code point maps the Hungarian
// accented letters to custom glyphs 1 through 7, U+00CD to 'i', U+00ED to
// 'I', and anything else to '?'. Bytes outside a sequence pass through
// unchanged. A last flag inside an unfinished sequence gives '?' and closes
// the string.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_lcd_charset_mapper (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [u2l_pkg::ByteW-1:0] in_byte,
  input  wire logic                      in_last,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [u2l_pkg::ByteW-1:0]      out_char,
  output logic                           out_last
);
  import u2l_pkg::*;

  logic             held_valid;
  logic [ByteW-1:0] held_byte;
  logic             held_last;
  logic             held_take;
  logic             can_load;
  logic [LeftW-1:0] bytes_left;
  res_t             res;

  // The held byte moves on when it yields nothing or the result register
  // has room for its character.
  assign held_take = held_valid && (!res.emit || can_load);

  u2l_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .take       (held_take),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .held_last  (held_last)
  );

  u2l_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .step       (held_take),
    .cur_byte   (held_byte),
    .cur_last   (held_last),
    .res        (res),
    .bytes_left (bytes_left)
  );

  u2l_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (held_take && res.emit),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .out_last  (out_last)
  );

  // A string end always leaves the decoder between sequences.
  assert property (@(posedge clk) disable iff (rst)
    held_take && held_last |=> bytes_left == '0)
    else $error("sequence state not cleared after last beat");

  // A held byte that cannot move stays in place with its payload.
  assert property (@(posedge clk) disable iff (rst)
    held_valid && !held_take |=> held_valid && $stable(held_byte) && $stable(held_last))
    else $error("held byte lost while stalled");

  // A byte that yields a result is loaded into the result register.
  assert property (@(posedge clk) disable iff (rst)
    held_take && res.emit |=> out_valid && out_char == $past(res.ch))
    else $error("result not captured");

  // Mid-sequence bytes without the last flag give no result.
  assert property (@(posedge clk) disable iff (rst)
    held_take && !held_last && bytes_left > LeftW'(1) |-> !res.emit)
    else $error("result emitted in the middle of a sequence");

endmodule

`default_nettype wire

@@ sv/u2l_in_reg.sv @@
// Input register stage that holds one byte beat until the decoder consumes it.
`timescale 1ns / 1ps
`default_nettype none

module u2l_in_reg (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [u2l_pkg::ByteW-1:0] in_byte,
  input  wire logic                      in_last,
  input  wire logic                      take,
  output logic                           held_valid,
  output logic [u2l_pkg::ByteW-1:0]      held_byte,
  output logic                           held_last
);
  import u2l_pkg::*;

  // The stage is free when empty or when its beat leaves this cycle.
  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= in_byte;
      held_last <= in_last;
    end
  end

endmodule

`default_nettype wire

@@ sv/u2l_decode.sv @@
// Sequence state and the single-pass decode of one byte into at most one character.
`timescale 1ns / 1ps
`default_nettype none

module u2l_decode (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      step,
  input  wire logic [u2l_pkg::ByteW-1:0] cur_byte,
  input  wire logic                      cur_last,
  output u2l_pkg::res_t                  res,
  output logic [u2l_pkg::LeftW-1:0]      bytes_left
);
  import u2l_pkg::*;

  logic [CodeW-1:0] code_accum;
  logic [CodeW-1:0] code_accum_next;
  logic [LeftW-1:0] bytes_left_next;
  logic [CodeW-1:0] code_step;
  logic [LeftW-1:0] left_step;

  always_comb begin
    code_step = code_accum;
    left_step = bytes_left;
    res.emit  = 1'b1;
    res.ch    = cur_byte;
    res.last  = cur_last;
    if (bytes_left != '0) begin
      // Continuation: only the low six bits count, whatever the top bits are.
      code_step = {code_accum[CodeW-7:0], cur_byte[5:0]};
      left_step = bytes_left - LeftW'(1);
      if (left_step != '0) begin
        res.emit = cur_last;
        res.ch   = CharUnknown;
      end else begin
        res.ch = map_code(code_step);
      end
    end else if ((cur_byte & Lead2Mask) == Lead2Pat) begin
      code_step = CodeW'(cur_byte[4:0]);
      left_step = Left2;
      res.emit  = cur_last;
      res.ch    = CharUnknown;
    end else if ((cur_byte & Lead3Mask) == Lead3Pat) begin
      code_step = CodeW'(cur_byte[3:0]);
      left_step = Left3;
      res.emit  = cur_last;
      res.ch    = CharUnknown;
    end else if ((cur_byte & Lead4Mask) == Lead4Pat) begin
      code_step = CodeW'(cur_byte[2:0]);
      left_step = Left4;
      res.emit  = cur_last;
      res.ch    = CharUnknown;
    end
    // The end of a string always leaves the decoder clean for the next one.
    code_accum_next = cur_last ? '0 : code_step;
    bytes_left_next = cur_last ? '0 : left_step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= '0;
      code_accum <= '0;
    end else if (step) begin
      bytes_left <= bytes_left_next;
      code_accum <= code_accum_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/u2l_out_reg.sv @@
// Result register that holds one display character beat until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none

module u2l_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire u2l_pkg::res_t        res,
  output logic                      can_load,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [u2l_pkg::ByteW-1:0] out_char,
  output logic                      out_last
);
  import u2l_pkg::*;

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      out_char <= res.ch;
      out_last <= res.last;
    end
  end

endmodule

`default_nettype wire

@@ dv/tb_utf8_to_lcd_charset_mapper.sv @@
// Self-checking testbench for the UTF-8 to display character mapper.
`timescale 1ns / 1ps

import u2l_pkg::*;

// Tracks the decoder state on the side, predicts the display character for every
// accepted byte beat and compares the characters leaving the block in order.
class char_scoreboard;

  typedef struct packed {
    logic [ByteW-1:0] ch;
    logic             last;
  } disp_char_t;

  logic [LeftW-1:0] cont_left = '0;
  logic [CodeW-1:0] code_pt   = '0;
  disp_char_t       expected_q[$];
  int unsigned      fails = 0;

  task report(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fails++;
  endtask

  function int unsigned pending();
    return expected_q.size();
  endfunction

  function logic [ByteW-1:0] glyph_for(logic [CodeW-1:0] cp);
    case (cp)
      21'h0000C1, 21'h0000E1: return GlyphAAcute;
      21'h0000C9, 21'h0000E9: return GlyphEAcute;
      21'h0000CD:             return CharLowerI;
      21'h0000ED:             return CharUpperI;
      21'h0000D3, 21'h0000F3: return GlyphOAcute;
      21'h0000D6, 21'h0000F6: return GlyphOUml;
      21'h000150, 21'h000151: return GlyphODblAc;
      21'h0000DA, 21'h0000FA: return GlyphUAcute;
      21'h0000DC, 21'h0000FC,
      21'h000170, 21'h000171: return GlyphUUmlDbl;
      default:                return CharUnknown;
    endcase
  endfunction

  // Called for every input beat; queues the character it produces, if any.
  function void note_byte(logic [ByteW-1:0] b, logic last);
    logic [ByteW-1:0] ch;
    logic             emit;
    emit = 1'b1;
    ch   = b;
    if (cont_left != '0) begin
      // Continuations contribute their low six bits whatever their top bits are.
      code_pt   = {code_pt[CodeW-7:0], b[5:0]};
      cont_left = cont_left - LeftW'(1);
      if (cont_left != '0) begin
        emit = last;
        ch   = CharUnknown;
      end else begin
        ch = glyph_for(code_pt);
      end
    end else if ((b & Lead2Mask) == Lead2Pat) begin
      code_pt   = CodeW'(b[4:0]);
      cont_left = Left2;
      emit      = last;
      ch        = CharUnknown;
    end else if ((b & Lead3Mask) == Lead3Pat) begin
      code_pt   = CodeW'(b[3:0]);
      cont_left = Left3;
      emit      = last;
      ch        = CharUnknown;
    end else if ((b & Lead4Mask) == Lead4Pat) begin
      code_pt   = CodeW'(b[2:0]);
      cont_left = Left4;
      emit      = last;
      ch        = CharUnknown;
    end
    if (last) begin
      cont_left = '0;
      code_pt   = '0;
    end
    if (emit) begin
      expected_q.push_back('{ch: ch, last: last});
    end
  endfunction

  task check_char(logic [ByteW-1:0] ch, logic last);
    disp_char_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected char 0x%02h last %0b", ch, last));
      return;
    end
    want = expected_q.pop_front();
    if (ch !== want.ch) begin
      report($sformatf("out_char 0x%02h, predicted 0x%02h", ch, want.ch));
    end
    if (last !== want.last) begin
      report($sformatf("out_last %0b, predicted %0b", last, want.last));
    end
  endtask

endclass

module tb_utf8_to_lcd_charset_mapper;

  // Cycles with no beat on either side before the run is declared hung.
  localparam int unsigned QuietLimit  = 1000;
  localparam int unsigned RandomBytes = 1100;
  localparam int unsigned MaxIdle     = 16;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic [ByteW-1:0] in_byte   = '0;
  logic             in_last   = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [ByteW-1:0] out_char;
  logic             out_last;

  char_scoreboard   sb = new();

  // When set, the matching side runs without any idle cycles for a while.
  bit               steady_in  = 1'b0;
  bit               steady_out = 1'b0;
  int unsigned      quiet_cycles = 0;
  int unsigned      sent_bytes = 0;
  logic [ByteW-1:0] text_q[$];

  // Code points that the block maps to something other than '?'.
  logic [CodeW-1:0] mapped_cps [18] = '{
    21'h0C1, 21'h0E1, 21'h0C9, 21'h0E9, 21'h0CD, 21'h0ED, 21'h0D3, 21'h0F3, 21'h0D6,
    21'h0F6, 21'h150, 21'h151, 21'h0DA, 21'h0FA, 21'h0DC, 21'h0FC, 21'h170, 21'h171
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  utf8_to_lcd_charset_mapper dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_char (out_char),
    .out_last (out_last)
  );

  function automatic int unsigned draw_idle(bit steady);
    if (steady) begin
      return 0;
    end
    return $urandom_range(0, MaxIdle);
  endfunction

  // Drives one byte beat. Called at a falling edge, returns at a falling edge.
  // With no idle cycles drawn, valid simply stays high into the next beat.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
    int unsigned idle;
    idle = draw_idle(steady_in);
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b, last);
    sent_bytes++;
    @(negedge clk);
  endtask

  // Sends the bytes in text_q; the final one carries the last flag if close is set.
  task automatic send_text(input bit close);
    foreach (text_q[i]) begin
      send_byte(text_q[i], close && (i == text_q.size() - 1));
    end
  endtask

  // A continuation byte, now and then with its top bits scrambled, which the
  // block must ignore.
  function automatic logic [ByteW-1:0] cont_byte(input logic [5:0] payload);
    logic [1:0] top;
    top = 2'b10;
    if ($urandom_range(0, 15) == 0) begin
      top = 2'($urandom_range(0, 3));
    end
    return {top, payload};
  endfunction

  // Appends cp to text_q as a sequence of nbytes bytes; a width larger than the
  // code point needs gives an overlong form.
  function automatic void push_code(input logic [CodeW-1:0] cp, input int unsigned nbytes);
    case (nbytes)
      2: begin
        text_q.push_back({3'b110, cp[10:6]});
        text_q.push_back(cont_byte(cp[5:0]));
      end
      3: begin
        text_q.push_back({4'b1110, cp[15:12]});
        text_q.push_back(cont_byte(cp[11:6]));
        text_q.push_back(cont_byte(cp[5:0]));
      end
      default: begin
        text_q.push_back({5'b11110, cp[20:18]});
        text_q.push_back(cont_byte(cp[17:12]));
        text_q.push_back(cont_byte(cp[11:6]));
        text_q.push_back(cont_byte(cp[5:0]));
      end
    endcase
  endfunction

  // Builds one random string in text_q. Most characters are well-formed
  // sequences; the rest are plain ASCII and arbitrary noise bytes. Some strings
  // end in the middle of a sequence.
  task automatic build_random_text();
    int unsigned nchars;
    int unsigned pick;
    int unsigned width;
    width  = 1;
    nchars = $urandom_range(1, 10);
    text_q.delete();
    repeat (nchars) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        width = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 4) : 2;
        push_code(mapped_cps[$urandom_range(0, 17)], width);
      end else if (pick < 55) begin
        width = 2;
        push_code(CodeW'($urandom_range(12'h080, 12'h7FF)), width);
      end else if (pick < 62) begin
        width = 3;
        push_code(CodeW'($urandom_range(16'h0800, 16'hFFFF)), width);
      end else if (pick < 67) begin
        width = 4;
        push_code(CodeW'($urandom_range(21'h010000, 21'h1FFFFF)), width);
      end else if (pick < 85) begin
        width = 1;
        text_q.push_back(ByteW'($urandom_range(0, 127)));
      end else begin
        width = 1;
        text_q.push_back(ByteW'($urandom_range(0, 255)));
      end
    end
    // Cut the final sequence short so the last flag lands inside it.
    if (width > 1 && $urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, width - 1)) void'(text_q.pop_back());
    end
  endtask

  // Output side: stall a random number of cycles, then take one character beat
  // and check it against the oldest prediction.
  initial begin : sink_side
    int unsigned stall;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      stall = draw_idle(steady_out);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_char(out_char, out_last);
      if ($urandom_range(0, 40) == 0) begin
        steady_out = !steady_out;
      end
      @(negedge clk);
    end
  end

  // Hang detector: a run that makes no progress on either side ends here.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : source_side
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Pass-through cases: plain ASCII, the zero byte, an invalid lead byte and
    // a stray continuation byte.
    text_q = '{8'h41, 8'h00, 8'hFF, 8'h80};
    send_text(1'b0);
    // Two-byte letters: a custom glyph, the swapped I letters, a double acute.
    text_q = '{8'hC3, 8'h81, 8'hC3, 8'h8D, 8'hC3, 8'hAD, 8'hC5, 8'hB1};
    send_text(1'b0);
    // An unmapped three-byte character and a real four-byte character.
    text_q = '{8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80};
    send_text(1'b0);
    // Overlong three-byte form of a mapped letter, a continuation with the wrong
    // top bits, then a lead byte closed by the last flag.
    text_q = '{8'hE0, 8'h83, 8'h81, 8'hC3, 8'h41, 8'hC3};
    send_text(1'b1);
    // Four-byte sequence cut short by the last flag.
    text_q = '{8'hF0, 8'h9F};
    send_text(1'b1);

    while (sent_bytes < RandomBytes) begin
      if ($urandom_range(0, 7) == 0) begin
        steady_in = !steady_in;
      end
      build_random_text();
      send_text(1'b1);
    end
    in_valid <= 1'b0;

    // Drain every predicted character, then give the pipeline time to show
    // anything extra that it should not produce.
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/u2l_pkg.sv
sv/u2l_in_reg.sv
sv/u2l_decode.sv
sv/u2l_out_reg.sv
sv/utf8_to_lcd_charset_mapper.sv
dv/tb_utf8_to_lcd_charset_mapper.sv
